FILE: sv/wdwr_pkg.sv
// ----------------------------------------------------------------------------
// wdwr_pkg: shared types and constants of the weighted draw block
// Field widths, operation and status codes, register indexes and the beat
// structs of the item and result channels.
// ----------------------------------------------------------------------------
package wdwr_pkg;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam int OP_W        = 2;
  localparam int IDX_FIELD_W = 9;
  localparam int SCORE_W     = 16;
  localparam int RND_W       = 31;
  localparam int STATUS_W    = 2;
  localparam int MAX_SCORE_W = 10;
  localparam int COUNT_W     = 10;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;

  // Largest weight is 1023 + 32768 + 1, which fits 16 unsigned bits.
  localparam int WEIGHT_W = 16;

  localparam logic [MAX_SCORE_W-1:0] MAX_SCORE_RST   = 10'd10;
  localparam logic [COUNT_W-1:0]     ENTRY_COUNT_RST = 10'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCORE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  localparam logic signed [SCORE_W-1:0] SCORE_TOP    = 16'sh7FFF;
  localparam logic signed [SCORE_W-1:0] SCORE_BOTTOM = 16'sh8000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DRAW  = 2'd2,
    OP_GRADE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_DRAW = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       operation;
    logic [IDX_FIELD_W-1:0]    entry_index;
    logic signed [SCORE_W-1:0] score_value;
    logic [RND_W-1:0]          random_value;
    logic                      answer_correct;
  } in_beat_t;

  typedef struct packed {
    status_t                   status;
    logic [IDX_FIELD_W-1:0]    drawn_index;
    logic signed [SCORE_W-1:0] score_now;
  } out_beat_t;

  localparam out_beat_t RES_ZERO = '{status: ST_OK, drawn_index: '0, score_now: '0};

endpackage

FILE: sv/wdwr_divider.sv
// ----------------------------------------------------------------------------
// wdwr_divider: sequential remainder unit
// Restoring division of the random value by the total weight, one quotient
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module wdwr_divider import wdwr_pkg::*; #(
  parameter int DIV_W = WEIGHT_W + $clog2(TABLE_DEPTH_DEF + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(RND_W + 1);

  logic [RND_W-1:0] dvd_r;
  logic [DIV_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;

  // The partial remainder stays below the divisor, so the shifted value
  // stays below twice the divisor and one extra bit holds the sign.
  assign rem_sh = {rem_r, dvd_r[RND_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= diff[DIV_W] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: sv/weighted_draw_without_replacement.sv
// A draw makes two table scans at one memory read per cycle, with the
// remainder unit run between them; a clear sweeps every drawn mark.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset is synchronous and active low; after reset
// a sweep clears the drawn marks before the first item.
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement: weighted draw over a score table
// Keeps a score and a drawn mark per entry in two synchronous memories and
// picks undrawn entries at random, weighted by how far each score stays
// below the configured ceiling.
// ----------------------------------------------------------------------------
module weighted_draw_without_replacement import wdwr_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  // The scan counter has to reach the entry count itself.
  localparam int CNT_W  = ADDR_W + 1;
  // Total weight over a full table.
  localparam int TOT_W  = WEIGHT_W + $clog2(TABLE_DEPTH + 1);
  // Signed width of max_score - score + 1 before the floor.
  localparam int WT_W   = WEIGHT_W + 2;

  // The sequencer. SWEEP clears the marks after reset and for a clear
  // item, SUM and PICK are the two scans of a draw, DIV waits on the
  // remainder unit, GRADE finishes the read-modify-write of a grade, and
  // FIN hands the result to the output register.
  typedef enum logic [6:0] {
    S_SWEEP = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_PICK  = 7'b0010000,
    S_GRADE = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [MAX_SCORE_W-1:0] max_score_r;
  logic [COUNT_W-1:0]     entry_count_r;

  // Session state.
  logic [ADDR_W-1:0] last_drawn_r, last_drawn_nxt;
  logic              draw_pending_r, draw_pending_nxt;
  logic              clr_item_r, clr_item_nxt;

  // Scan pipeline: issue, memory read, weight, accumulate.
  logic [CNT_W-1:0]          scan_addr_r, scan_addr_nxt;
  logic                      rd_valid_r;
  logic [ADDR_W-1:0]         rd_idx_r;
  logic                      w_valid_r;
  logic [WEIGHT_W-1:0]       w_r;
  logic [ADDR_W-1:0]         w_idx_r;
  logic signed [SCORE_W-1:0] w_score_r;

  logic [TOT_W-1:0]          total_r, total_nxt;
  logic [TOT_W-1:0]          sum_r, sum_nxt;
  logic [TOT_W-1:0]          sum_add;
  logic [TOT_W-1:0]          rem_r, rem_nxt;
  logic                      found_r, found_nxt;
  logic [ADDR_W-1:0]         pick_idx_r, pick_idx_nxt;
  logic signed [SCORE_W-1:0] pick_score_r, pick_score_nxt;

  // Item fields kept for the length of the item.
  logic [RND_W-1:0] rnd_r;
  logic             correct_r;

  // Result waiting for the output register, and the output register.
  out_beat_t res_r, res_nxt;
  out_beat_t out_beat_r;
  logic      out_valid_r, out_valid_nxt;
  logic      out_load;

  // Memories and their ports.
  logic signed [SCORE_W-1:0] score_mem [TABLE_DEPTH];
  logic                      mark_mem  [TABLE_DEPTH];
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [SCORE_W-1:0] score_q;
  logic                      mark_q;
  logic                      score_we;
  logic [ADDR_W-1:0]         score_waddr;
  logic signed [SCORE_W-1:0] score_wdata;
  logic                      mark_we;
  logic [ADDR_W-1:0]         mark_waddr;
  logic                      mark_wdata;

  // Miscellaneous datapath.
  logic [CNT_W-1:0]          n_active;
  logic                      issue;
  logic                      scan_drained;
  logic                      in_acc;
  logic signed [WT_W-1:0]    wt_full;
  logic [WEIGHT_W-1:0]       wt;
  logic signed [SCORE_W-1:0] grade_score;
  logic                      div_start;
  logic                      div_done;
  logic [TOT_W-1:0]          div_rem;

  // An entry count above the table depth behaves as the full table.
  assign n_active = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(entry_count_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // A read is issued every cycle of a scan until all entries in use have
  // been addressed. The scan is over once the last read has also passed
  // the weight and accumulate stages, so the totals are final.
  assign issue        = ((state_r == S_SUM) || (state_r == S_PICK)) && (scan_addr_r < n_active);
  assign scan_drained = (scan_addr_r >= n_active) && !rd_valid_r && !w_valid_r;

  // In idle the read port points at the last drawn entry, so a grade has
  // its score in the cycle after it is accepted.
  assign rd_addr = (state_r == S_IDLE) ? last_drawn_r : scan_addr_r[ADDR_W-1:0];

  // Weight of the entry just read: max_score - score + 1, floored at one.
  assign wt_full = $signed({{(WT_W-MAX_SCORE_W){1'b0}}, max_score_r})
                 - $signed({{(WT_W-SCORE_W){score_q[SCORE_W-1]}}, score_q})
                 + $signed(WT_W'(1));
  assign wt = (wt_full[WT_W-1] || (wt_full == '0)) ? WEIGHT_W'(1) : wt_full[WEIGHT_W-1:0];

  // Running sum of the pick scan.
  assign sum_add = sum_r + TOT_W'(w_r);

  // A grade moves the score by one and saturates at the 16-bit limits.
  always_comb begin
    if (correct_r) begin
      grade_score = (score_q == SCORE_TOP) ? score_q : score_q + 16'sd1;
    end else begin
      grade_score = (score_q == SCORE_BOTTOM) ? score_q : score_q - 16'sd1;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    scan_addr_nxt    = scan_addr_r;
    last_drawn_nxt   = last_drawn_r;
    draw_pending_nxt = draw_pending_r;
    clr_item_nxt     = clr_item_r;
    total_nxt        = total_r;
    sum_nxt          = sum_r;
    rem_nxt          = rem_r;
    found_nxt        = found_r;
    pick_idx_nxt     = pick_idx_r;
    pick_score_nxt   = pick_score_r;
    res_nxt          = res_r;
    out_load         = 1'b0;
    div_start        = 1'b0;
    score_we         = 1'b0;
    score_waddr      = last_drawn_r;
    score_wdata      = grade_score;
    mark_we          = 1'b0;
    mark_waddr       = pick_idx_r;
    mark_wdata       = 1'b1;

    if (issue) begin
      scan_addr_nxt = scan_addr_r + CNT_W'(1);
    end

    case (state_r)
      S_SWEEP: begin
        // One mark cleared per cycle; no item is taken meanwhile.
        mark_we       = 1'b1;
        mark_waddr    = scan_addr_r[ADDR_W-1:0];
        mark_wdata    = 1'b0;
        scan_addr_nxt = scan_addr_r + CNT_W'(1);
        if (scan_addr_r == CNT_W'(TABLE_DEPTH - 1)) begin
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_beat.operation)
            OP_WRITE: begin
              // Writes past the end of the table are dropped.
              score_we    = (32'(in_beat.entry_index) < 32'(TABLE_DEPTH));
              score_waddr = ADDR_W'(in_beat.entry_index);
              score_wdata = in_beat.score_value;
              res_nxt     = RES_ZERO;
              state_nxt   = S_FIN;
            end
            OP_CLEAR: begin
              draw_pending_nxt = 1'b0;
              clr_item_nxt     = 1'b1;
              scan_addr_nxt    = '0;
              res_nxt          = RES_ZERO;
              state_nxt        = S_SWEEP;
            end
            OP_DRAW: begin
              scan_addr_nxt = '0;
              total_nxt     = '0;
              state_nxt     = S_SUM;
            end
            OP_GRADE: begin
              if (draw_pending_r) begin
                state_nxt = S_GRADE;
              end else begin
                res_nxt        = RES_ZERO;
                res_nxt.status = ST_NO_DRAW;
                state_nxt      = S_FIN;
              end
            end
            default: begin
              res_nxt   = RES_ZERO;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SUM: begin
        if (w_valid_r) begin
          total_nxt = total_r + TOT_W'(w_r);
        end
        if (scan_drained) begin
          if (total_r == '0) begin
            // Every entry in use is drawn, or none is in use.
            draw_pending_nxt = 1'b0;
            res_nxt          = RES_ZERO;
            res_nxt.status   = ST_EMPTY;
            state_nxt        = S_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rem_nxt       = div_rem;
          scan_addr_nxt = '0;
          sum_nxt       = '0;
          found_nxt     = 1'b0;
          state_nxt     = S_PICK;
        end
      end
      S_PICK: begin
        // The first undrawn entry whose running sum passes the remainder
        // wins; entries after it still drain through but change nothing.
        if (w_valid_r && !found_r) begin
          sum_nxt = sum_add;
          if (sum_add > rem_r) begin
            found_nxt      = 1'b1;
            pick_idx_nxt   = w_idx_r;
            pick_score_nxt = w_score_r;
          end
        end
        if (scan_drained) begin
          mark_we             = 1'b1;
          mark_waddr          = pick_idx_r;
          mark_wdata          = 1'b1;
          last_drawn_nxt      = pick_idx_r;
          draw_pending_nxt    = 1'b1;
          res_nxt.status      = ST_OK;
          res_nxt.drawn_index = IDX_FIELD_W'(pick_idx_r);
          res_nxt.score_now   = pick_score_r;
          state_nxt           = S_FIN;
        end
      end
      S_GRADE: begin
        // The score of the last drawn entry was read in idle; write back.
        score_we            = 1'b1;
        score_waddr         = last_drawn_r;
        score_wdata         = grade_score;
        draw_pending_nxt    = 1'b0;
        res_nxt.status      = ST_OK;
        res_nxt.drawn_index = IDX_FIELD_W'(last_drawn_r);
        res_nxt.score_now   = grade_score;
        state_nxt           = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_SWEEP;
      scan_addr_r    <= '0;
      last_drawn_r   <= '0;
      draw_pending_r <= 1'b0;
      clr_item_r     <= 1'b0;
      found_r        <= 1'b0;
      rd_valid_r     <= 1'b0;
      w_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      max_score_r    <= MAX_SCORE_RST;
      entry_count_r  <= ENTRY_COUNT_RST;
    end else begin
      state_r        <= state_nxt;
      scan_addr_r    <= scan_addr_nxt;
      last_drawn_r   <= last_drawn_nxt;
      draw_pending_r <= draw_pending_nxt;
      clr_item_r     <= clr_item_nxt;
      found_r        <= found_nxt;
      rd_valid_r     <= issue;
      w_valid_r      <= rd_valid_r && !mark_q;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_SCORE:   max_score_r   <= cfg_data[MAX_SCORE_W-1:0];
          CFG_ENTRY_COUNT: entry_count_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r     <= scan_addr_r[ADDR_W-1:0];
    w_r          <= wt;
    w_idx_r      <= rd_idx_r;
    w_score_r    <= score_q;
    total_r      <= total_nxt;
    sum_r        <= sum_nxt;
    rem_r        <= rem_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_score_r <= pick_score_nxt;
    res_r        <= res_nxt;
    if (in_acc) begin
      rnd_r     <= in_beat.random_value;
      correct_r <= in_beat.answer_correct;
    end
    if (out_load) begin
      out_beat_r <= res_r;
    end
  end

  // Score table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    score_q <= score_mem[rd_addr];
  end

  // Drawn marks: same read address as the score table.
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_q <= mark_mem[rd_addr];
  end

  wdwr_divider #(
    .DIV_W(TOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (total_r),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: sv/wdwr_checker.sv
// ----------------------------------------------------------------------------
// wdwr_checker: port-level checks of the weighted draw block
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module wdwr_checker import wdwr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // Items are worked on one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken right after an accepted one");

  // Failed draws and grades carry no entry and no score.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.status == ST_EMPTY || out_beat.status == ST_NO_DRAW)
    |-> out_beat.drawn_index == '0 && out_beat.score_now == '0)
    else $error("failed result carries an entry or score");

  // Reset empties the output and starts the mark sweep.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not idle and sweeping after reset");

endmodule

bind weighted_draw_without_replacement wdwr_checker u_wdwr_checker (.*);

FILE: bench/weighted_draw_without_replacement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement_checker: result predictor and comparator
// Watches the item, result and register ports, keeps its own copy of the
// score table, drawn marks and registers, and checks every result beat
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module weighted_draw_without_replacement_checker import wdwr_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_beat,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    waiting
);

  logic signed [SCORE_W-1:0] scores [DEPTH];
  bit                        drawn [DEPTH];
  int                        last_pick = 0;
  bit                        pick_open = 1'b0;
  int                        ceiling = int'(MAX_SCORE_RST);
  int                        in_use = int'(ENTRY_COUNT_RST);
  out_beat_t                 owed_q [$];
  int                        fail_n = 0;
  int                        result_n = 0;

  function automatic int weight(int j);
    int w;
    w = ceiling - int'(scores[j]) + 1;
    return (w < 1) ? 1 : w;
  endfunction

  // Applies one accepted item to the local state and returns its result.
  function automatic out_beat_t draw_result(in_beat_t b);
    out_beat_t res;
    int        n;
    int        total;
    int        r;
    int        acc;
    int        pick;
    int        s;
    bit        found;
    res = RES_ZERO;
    case (b.operation)
      OP_WRITE: begin
        if (b.entry_index < DEPTH) scores[b.entry_index] = b.score_value;
      end
      OP_CLEAR: begin
        foreach (drawn[j]) drawn[j] = 1'b0;
        pick_open = 1'b0;
      end
      OP_DRAW: begin
        n = (in_use > DEPTH) ? DEPTH : in_use;
        total = 0;
        for (int j = 0; j < n; j++) if (!drawn[j]) total += weight(j);
        if (total == 0) begin
          pick_open  = 1'b0;
          res.status = ST_EMPTY;
        end else begin
          r     = int'(b.random_value % total);
          acc   = 0;
          pick  = 0;
          found = 1'b0;
          for (int j = 0; j < n && !found; j++) begin
            if (!drawn[j]) begin
              acc += weight(j);
              if (acc > r) begin
                pick  = j;
                found = 1'b1;
              end
            end
          end
          drawn[pick]     = 1'b1;
          last_pick       = pick;
          pick_open       = 1'b1;
          res.drawn_index = IDX_FIELD_W'(pick);
          res.score_now   = scores[pick];
        end
      end
      default: begin
        if (!pick_open) begin
          res.status = ST_NO_DRAW;
        end else begin
          s = int'(scores[last_pick]);
          if (b.answer_correct) begin
            if (s < SCORE_TOP) s++;
          end else if (s > SCORE_BOTTOM) begin
            s--;
          end
          scores[last_pick] = SCORE_W'(s);
          pick_open         = 1'b0;
          res.drawn_index   = IDX_FIELD_W'(last_pick);
          res.score_now     = SCORE_W'(s);
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t due;
    if (!rst_n) begin
      owed_q.delete();
      foreach (drawn[j]) drawn[j] = 1'b0;
      last_pick = 0;
      pick_open = 1'b0;
      ceiling   = int'(MAX_SCORE_RST);
      in_use    = int'(ENTRY_COUNT_RST);
    end else begin
      // Results are checked before this edge's item is predicted, so a
      // result can never be matched against its own item's prediction.
      if (out_valid && !out_stall) begin
        result_n++;
        if (owed_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("Result beat %0d arrived with nothing owed: status %0d index %0d score %0d",
                     result_n, out_beat.status, out_beat.drawn_index, out_beat.score_now);
        end else begin
          due = owed_q.pop_front();
          if (out_beat.status !== due.status || out_beat.drawn_index !== due.drawn_index ||
              out_beat.score_now !== due.score_now) begin
            fail_n++;
            if (fail_n <= 10)
              $display("Result beat %0d: expected status %0d index %0d score %0d, got %0d %0d %0d",
                       result_n, due.status, due.drawn_index, due.score_now,
                       out_beat.status, out_beat.drawn_index, out_beat.score_now);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_SCORE) ceiling = int'(cfg_data);
        else if (cfg_index == CFG_ENTRY_COUNT) in_use = int'(cfg_data);
      end
      if (in_valid && !in_stall) owed_q.push_back(draw_result(in_beat));
    end
    mismatches <= fail_n;
    waiting    <= owed_q.size();
  end

endmodule

FILE: bench/weighted_draw_without_replacement_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement_tb: self-checking bench of the weighted draw
// Drives score writes, session clears, draws and grades through a series of
// register settings and idling patterns; a separate checker predicts every
// result beat and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module weighted_draw_without_replacement_tb;
  import wdwr_pkg::*;

  // Watchdog limit; it leaves a wide margin over the slowest run.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Long receiver hold-off used once to fill the block and stall its input.
  localparam int HOLD_LEN    = 300;
  // Every item returns exactly one result, so little settling is needed
  // before a register write once nothing is owed.
  localparam int SETTLE      = 8;
  // Quiet cycles at the end to catch any stray result beat.
  localparam int TAIL        = 64;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_beat;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int waiting;

  int cyc              = 0;
  int hold_from        = -1;
  int stall_pct        = 0;
  int send_idle_pct    = 0;
  int ceiling_now      = int'(MAX_SCORE_RST);
  int active_now       = int'(ENTRY_COUNT_RST);
  int beats_sent       = 0;
  int settings_used    = 1;
  int full_table_draws = 0;

  // Entries that have been given a score. A draw reads every entry in use,
  // so entries are always written before a draw reaches them.
  bit written [TABLE_DEPTH_DEF];

  weighted_draw_without_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  weighted_draw_without_replacement_checker draw_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always #1 clk = ~clk;

  // Cycle count and watchdog. A run that hangs ends here as a failure.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still owed", cyc, waiting);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. It stalls at random per cycle, except during the one long
  // hold-off, which is counted here against the cycle counter.
  always @(posedge clk) begin
    if (hold_from >= 0 && cyc >= hold_from && cyc < hold_from + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_beat_t item(op_t op, int idx, int score, int unsigned rnd, bit ans);
    in_beat_t b;
    b.operation      = op;
    b.entry_index    = IDX_FIELD_W'(idx);
    b.score_value    = SCORE_W'(score);
    b.random_value   = RND_W'(rnd);
    b.answer_correct = ans;
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.operation      = op_t'($urandom_range(3));
    b.entry_index    = IDX_FIELD_W'($urandom);
    b.score_value    = SCORE_W'($urandom);
    b.random_value   = RND_W'($urandom);
    b.answer_correct = 1'($urandom);
    return b;
  endfunction

  // Scores mostly sit near the ceiling so that weights differ in an
  // interesting way; the saturation limits and wild values show up too.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return SCORE_TOP;
    if (roll < 16) return SCORE_BOTTOM;
    if (roll < 30) return SCORE_W'($urandom);
    return SCORE_W'(int'($urandom_range(ceiling_now + 80)) - 40);
  endfunction

  // Offers one beat and returns after the edge that accepts it. Idle cycles
  // come before the beat with the phase's per-cycle probability.
  task automatic send(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.operation == OP_WRITE) written[b.entry_index] = 1'b1;
    if (b.operation == OP_DRAW && active_now >= TABLE_DEPTH_DEF) full_table_draws++;
    beats_sent++;
  endtask

  // Drops valid and waits until every owed result has come back. The first
  // edge lets the checker count a beat accepted at the previous edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers, the ceiling first and then the entry count, on consecutive edges.
  task automatic set_regs(int max_s, int count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_SCORE;
    cfg_data  <= CFG_DATA_W'(max_s);
    @(posedge clk);
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    ceiling_now = max_s;
    active_now  = (count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : count;
    settings_used++;
  endtask

  task automatic cover_entries(int n);
    for (int i = 0; i < n; i++)
      if (!written[i]) send(item(OP_WRITE, i, pick_score(), $urandom, 1'($urandom)));
  endtask

  // Quiz-like traffic: most draws are followed by a grade, clears start new
  // sessions, and writes, lone grades and repeated draws act as noise.
  // Small tables run dry quickly, which exercises the empty case often.
  task automatic random_items(int budget);
    in_beat_t b;
    int       done;
    int       roll;
    done = 0;
    while (done < budget) begin
      b    = random_beat();
      roll = $urandom_range(99);
      if (roll < 8) begin
        b.operation = OP_CLEAR;
      end else if (roll < 22) begin
        b.operation   = OP_WRITE;
        b.score_value = pick_score();
        if (active_now > 0 && $urandom_range(1))
          b.entry_index = IDX_FIELD_W'($urandom_range(active_now - 1));
      end else if (roll < 27) begin
        b.operation = OP_GRADE;
      end else begin
        b.operation = OP_DRAW;
        send(b);
        done++;
        b = random_beat();
        b.operation = ($urandom_range(99) < 85) ? OP_GRADE : OP_DRAW;
      end
      send(b);
      done++;
    end
  endtask

  // One phase: new register settings while idle, scores for every entry in
  // use, then random traffic under the given idling pattern. A squeezed
  // phase starts the long result hold-off right away, while the sender
  // keeps offering beats.
  task automatic run_phase(int max_s, int count, int idle, int stall, int budget, bit squeeze);
    wait_idle();
    set_regs(max_s, count);
    send_idle_pct = idle;
    stall_pct <= stall;
    if (squeeze) hold_from <= cyc + 4;
    cover_entries((count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : count);
    random_items(budget);
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MAX_SCORE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no entries in use: a draw finds nothing, and a grade
    // has no pending draw. Then the score limits go into a few entries.
    send(item(OP_DRAW, 0, 0, 0, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b1));
    send(item(OP_WRITE, 0, 32767, 0, 1'b0));
    send(item(OP_WRITE, 511, -32768, 31'h7FFFFFFF, 1'b1));
    send(item(OP_WRITE, 1, -32768, 0, 1'b0));
    send(item(OP_WRITE, 2, 0, 0, 1'b0));
    send(item(OP_WRITE, 3, 5, 0, 1'b1));

    // Single entry with a zero ceiling: grading must saturate at the top,
    // then, after a rewrite, at the bottom. A second grade finds no draw.
    wait_idle();
    set_regs(0, 1);
    send(item(OP_CLEAR, 0, 0, 0, 1'b0));
    send(item(OP_DRAW, 0, 0, 31'h7FFFFFFF, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b1));
    send(item(OP_WRITE, 0, -32768, 0, 1'b0));
    send(item(OP_CLEAR, 0, 0, 0, 1'b0));
    send(item(OP_DRAW, 0, 0, 0, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b1));

    // Four entries at the highest ceiling: draw them all, then one more,
    // which runs dry and drops the pending draw; a clear starts over.
    wait_idle();
    set_regs(1023, 4);
    send(item(OP_CLEAR, 0, 0, 0, 1'b0));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b1));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b1));
    send(item(OP_CLEAR, 0, 0, 0, 1'b0));
    send(item(OP_DRAW, 0, 0, $urandom, 1'b0));
    send(item(OP_GRADE, 0, 0, 0, 1'b0));

    // Random phases: each idling pattern, both register extremes, and an
    // entry count beyond the table, which acts as the full table.
    run_phase(10, 8, 0, 0, 90, 1'b0);
    run_phase(0, 16, 58, 0, 90, 1'b0);
    run_phase(1023, 3, 0, 58, 90, 1'b0);
    run_phase($urandom_range(1023), 12, 26, 26, 90, 1'b0);
    run_phase(1023, 1023, 26, 26, 24, 1'b1);
    run_phase(0, 512, 0, 58, 16, 1'b0);
    run_phase($urandom_range(1023), $urandom_range(1, 16), 0, 0, 90, 1'b0);

    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d item beats over %0d register settings, %0d draws over the full table.",
             beats_sent, settings_used, full_table_draws);
    $display("Idling patterns: none, sender, receiver, both, plus one long result hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
